### design/fsn_pkg.sv
// ----------------------------------------------------------------------------
// fsn_pkg
// shared types and constants for the fixed-radius neighbor scan
// ----------------------------------------------------------------------------
`default_nettype none

package fsn_pkg;

   localparam int MAX_POINTS = 32;
   localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   localparam int COORD_W    = 16;
   localparam int ID_W       = 16;
   localparam int SLOT_W     = 5;
   localparam int SQ_W       = 32;
   localparam int DIST_W     = 34;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int PCOUNT_W   = 6;
   localparam int RADIUS_W   = 16;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic KIND_NEIGHBOR = 1'b0;
   localparam logic KIND_SUMMARY  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_POINT_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS      = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } point_type;

endpackage

`default_nettype wire

### design/fixed_radius_neighbor_scan.sv
// ----------------------------------------------------------------------------
// fixed_radius_neighbor_scan
// brute-force fixed-radius neighbor search over a ring of 3-D point cells
// ----------------------------------------------------------------------------
// A load beat (mode 0) writes one slot and returns nothing. A query beat
// (mode 1) rotates the ring of MAX_POINTS cells once, one slot per cycle
// past the distance unit while the result port is not stalling; a neighbor
// beat that waits on the result port holds the rotation. Neighbor beats come
// in slot order, followed by one summary beat with last set. The next request
// is taken once the query's summary sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_radius_neighbor_scan (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_mode,
   input  wire logic [fsn_pkg::SLOT_W-1:0]    req_slot,
   input  wire logic [fsn_pkg::ID_W-1:0]      req_point_id,
   input  wire logic signed [fsn_pkg::COORD_W-1:0] req_coord_x,
   input  wire logic signed [fsn_pkg::COORD_W-1:0] req_coord_y,
   input  wire logic signed [fsn_pkg::COORD_W-1:0] req_coord_z,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_kind,
   output logic [fsn_pkg::ID_W-1:0]           rsp_result_id,
   output logic [fsn_pkg::DIST_W-1:0]         rsp_dist_sq,
   output logic                               rsp_found,
   output logic                               rsp_last,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [fsn_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fsn_pkg::CSR_DATA_W-1:0] csr_data
);
   import fsn_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_SUM   = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [PCOUNT_W-1:0] pcount_ff, pcount_in;
   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [SQ_W-1:0]     r2_ff, r2_in;
   logic [COORD_W-1:0]  qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;

   logic                valid_a_ff, valid_a_in;
   logic                inr_a_ff, inr_a_in;
   logic                last_a_ff, last_a_in;
   logic [ID_W-1:0]     id_a_ff, id_a_in;

   logic                found_ff, found_in;
   logic [DIST_W-1:0]   best_d_ff, best_d_in;
   logic [ID_W-1:0]     best_id_ff, best_id_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [DIST_W-1:0]   rsp_dist_ff, rsp_dist_in;
   logic                rsp_found_ff, rsp_found_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                adv;
   logic                scan_step;
   logic                req_fire;
   logic                load_wr;
   logic                hit;
   logic [DIST_W-1:0]   sum_sq;
   point_type           load_pt;
   point_type           ring [MAX_POINTS];

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign load_wr   = req_fire && (req_mode == MODE_LOAD);
   assign scan_step = (state_ff == ST_SCAN) && adv;

   assign load_pt = '{id: req_point_id, x: req_coord_x, y: req_coord_y, z: req_coord_z};

   // point ring, head cell is slot 0 of the current rotation
   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      localparam int NXT = (i + 1) % MAX_POINTS;
      fsn_cell u_cell (
         .clock    (clock),
         .shift_en (scan_step),
         .wr_en    (load_wr && (int'(req_slot) == i)),
         .wr_pt    (load_pt),
         .nbr_pt   (ring[NXT]),
         .pt       (ring[i])
      );
   end

   fsn_dist u_dist (
      .clock  (clock),
      .en     (adv),
      .pt     (ring[0]),
      .qx     (qx_ff),
      .qy     (qy_ff),
      .qz     (qz_ff),
      .sum_sq (sum_sq)
   );

   assign hit = valid_a_ff && inr_a_ff && (sum_sq < DIST_W'(r2_ff));

   always_comb begin
      state_in     = state_ff;
      pcount_in    = pcount_ff;
      radius_in    = radius_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      r2_in        = r2_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      qz_in        = qz_ff;
      valid_a_in   = valid_a_ff;
      inr_a_in     = inr_a_ff;
      last_a_in    = last_a_ff;
      id_a_in      = id_a_ff;
      found_in     = found_ff;
      best_d_in    = best_d_ff;
      best_id_in   = best_id_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_found_in = rsp_found_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_POINT_COUNT: pcount_in = csr_data[PCOUNT_W-1:0];
            REG_RADIUS:      radius_in = csr_data[RADIUS_W-1:0];
            default:         ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // query start
      if (req_fire && (req_mode == MODE_QUERY)) begin
         state_in   = ST_SCAN;
         idx_in     = '0;
         n_in       = (32'(pcount_ff) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                    : CNT_W'(pcount_ff);
         r2_in      = SQ_W'(radius_ff) * SQ_W'(radius_ff);
         qx_in      = req_coord_x;
         qy_in      = req_coord_y;
         qz_in      = req_coord_z;
         found_in   = 1'b0;
         best_d_in  = '0;
         best_id_in = '0;
      end

      if (adv) begin
         // squares stage fed from the ring head
         valid_a_in = (state_ff == ST_SCAN);
         inr_a_in   = CNT_W'(idx_ff) < n_ff;
         last_a_in  = (idx_ff == IDX_W'(MAX_POINTS - 1));
         id_a_in    = ring[0].id;

         if (state_ff == ST_SCAN) begin
            if (idx_ff == IDX_W'(MAX_POINTS - 1)) begin
               idx_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // compare stage
         if (hit) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_NEIGHBOR;
            rsp_id_in    = id_a_ff;
            rsp_dist_in  = sum_sq;
            rsp_found_in = 1'b0;
            rsp_last_in  = 1'b0;
            if (!found_ff || (sum_sq < best_d_ff)) begin
               found_in   = 1'b1;
               best_d_in  = sum_sq;
               best_id_in = id_a_ff;
            end
         end
         if (valid_a_ff && last_a_ff) begin
            state_in = ST_SUM;
         end

         if (state_ff == ST_SUM) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_SUMMARY;
            rsp_id_in    = best_id_ff;
            rsp_dist_in  = best_d_ff;
            rsp_found_in = found_ff;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pcount_ff    <= '0;
         radius_ff    <= '0;
         idx_ff       <= '0;
         valid_a_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pcount_ff    <= pcount_in;
         radius_ff    <= radius_in;
         idx_ff       <= idx_in;
         valid_a_ff   <= valid_a_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      r2_ff        <= r2_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      qz_ff        <= qz_in;
      inr_a_ff     <= inr_a_in;
      last_a_ff    <= last_a_in;
      id_a_ff      <= id_a_in;
      best_d_ff    <= best_d_in;
      best_id_ff   <= best_id_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_result_id = rsp_id_ff;
   assign rsp_dist_sq   = rsp_dist_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_last      = rsp_last_ff;

   // ring position only moves during a scan
   a_idx_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SCAN) |-> (idx_ff == '0))
      else $error("scan index not at home outside scan");

   // no point in flight while idle or emitting the summary
   a_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) || (state_ff == ST_SUM)) |-> !valid_a_ff)
      else $error("squares stage busy outside scan");

   // every neighbor lies strictly inside the radius
   a_nbr_inside: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_NEIGHBOR)) |-> (rsp_dist_ff < DIST_W'(r2_ff)))
      else $error("neighbor outside radius");

   // a summary without a find carries zero distance
   a_sum_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_SUMMARY) && !rsp_found_ff)
         |-> ((rsp_dist_ff == '0) && (rsp_id_ff == '0)))
      else $error("empty summary not zero");

   // a neighbor beat is never left behind in the idle state
   a_nbr_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_NEIGHBOR)) |-> (state_ff != ST_IDLE))
      else $error("neighbor pending while idle");

endmodule

`default_nettype wire

### design/fsn_cell.sv
// ----------------------------------------------------------------------------
// fsn_cell
// one table slot of the point ring; loads by slot write, hands its point
// to the neighbor below while the ring rotates
// ----------------------------------------------------------------------------
`default_nettype none

module fsn_cell (
   input  wire logic              clock,
   input  wire logic              shift_en,
   input  wire logic              wr_en,
   input  wire fsn_pkg::point_type wr_pt,
   input  wire fsn_pkg::point_type nbr_pt,
   output fsn_pkg::point_type     pt
);
   import fsn_pkg::*;

   point_type pt_ff;
   point_type pt_in;

   always_comb begin
      pt_in = pt_ff;
      if (wr_en) begin
         pt_in = wr_pt;
      end else if (shift_en) begin
         pt_in = nbr_pt;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff <= pt_in;
   end

   assign pt = pt_ff;

endmodule

`default_nettype wire

### design/fsn_dist.sv
// ----------------------------------------------------------------------------
// fsn_dist
// squared distance of the head point to the query: registered squares,
// then the three-term sum
// ----------------------------------------------------------------------------
`default_nettype none

module fsn_dist (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire fsn_pkg::point_type          pt,
   input  wire logic [fsn_pkg::COORD_W-1:0] qx,
   input  wire logic [fsn_pkg::COORD_W-1:0] qy,
   input  wire logic [fsn_pkg::COORD_W-1:0] qz,
   output logic [fsn_pkg::DIST_W-1:0]       sum_sq
);
   import fsn_pkg::*;

   logic signed [COORD_W:0]     dx, dy, dz;
   logic signed [2*COORD_W+1:0] px, py, pz;
   logic [SQ_W-1:0]             sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SQ_W-1:0]             sq_x_in, sq_y_in, sq_z_in;

   always_comb begin
      dx = $signed({pt.x[COORD_W-1], pt.x}) - $signed({qx[COORD_W-1], qx});
      dy = $signed({pt.y[COORD_W-1], pt.y}) - $signed({qy[COORD_W-1], qy});
      dz = $signed({pt.z[COORD_W-1], pt.z}) - $signed({qz[COORD_W-1], qz});
      px = dx * dx;
      py = dy * dy;
      pz = dz * dz;
      sq_x_in = sq_x_ff;
      sq_y_in = sq_y_ff;
      sq_z_in = sq_z_ff;
      if (en) begin
         sq_x_in = px[SQ_W-1:0];
         sq_y_in = py[SQ_W-1:0];
         sq_z_in = pz[SQ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
      sq_z_ff <= sq_z_in;
   end

   assign sum_sq = DIST_W'(sq_x_ff) + DIST_W'(sq_y_ff) + DIST_W'(sq_z_ff);

endmodule

`default_nettype wire

### dv/fixed_radius_neighbor_scan_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_radius_neighbor_scan_tb
// self-checking bench for the fixed-radius neighbor scan
// ----------------------------------------------------------------------------
// Loads points into the slot table, runs queries against it and predicts
// every neighbor beat and the closing summary beat from a local copy of the
// table, the point count and the radius. Directed queries cover the field
// extremes, an empty table, a zero radius, the radius boundary, equal
// distances and counts above the table size; random phases then load
// clustered points and query around them, with random gaps on the request
// side and random stalls on the response side, and a final stretch without
// either.
// ----------------------------------------------------------------------------

module fixed_radius_neighbor_scan_tb;

   import fsn_pkg::*;

   typedef struct {
      logic              kind;
      logic [ID_W-1:0]   id;
      logic [DIST_W-1:0] dist_sq;
      logic              found;
      logic              last;
   } scan_beat_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_mode = MODE_LOAD;
   logic [SLOT_W-1:0]      req_slot = '0;
   logic [ID_W-1:0]        req_point_id = '0;
   logic [COORD_W-1:0]     req_coord_x = '0;
   logic [COORD_W-1:0]     req_coord_y = '0;
   logic [COORD_W-1:0]     req_coord_z = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_kind;
   logic [ID_W-1:0]        rsp_result_id;
   logic [DIST_W-1:0]      rsp_dist_sq;
   logic                   rsp_found;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = REG_POINT_COUNT;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   point_type              point_table [MAX_POINTS];
   logic [PCOUNT_W-1:0]    cfg_point_count = '0;
   logic [RADIUS_W-1:0]    cfg_radius = '0;
   scan_beat_type          scan_beats_due [$];
   int                     mismatch_count = 0;
   bit                     idle_enable = 1'b1;
   int                     stall_left = 0;

   fixed_radius_neighbor_scan DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_slot      (req_slot),
      .req_point_id  (req_point_id),
      .req_coord_x   (req_coord_x),
      .req_coord_y   (req_coord_y),
      .req_coord_z   (req_coord_z),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_result_id (rsp_result_id),
      .rsp_dist_sq   (rsp_dist_sq),
      .rsp_found     (rsp_found),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] square_diff(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      logic [COORD_W:0]        m;
      d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
      m = d[COORD_W] ? -d : d;
      return 32'(m[COORD_W-1:0]) * 32'(m[COORD_W-1:0]);
   endfunction

   function automatic void predict_scan(logic [COORD_W-1:0] qx, logic [COORD_W-1:0] qy,
                                        logic [COORD_W-1:0] qz);
      int                n;
      logic [DIST_W-1:0] r2;
      logic [DIST_W-1:0] d;
      logic [DIST_W-1:0] best_d;
      logic [ID_W-1:0]   best_id;
      logic              hit;
      n = (cfg_point_count > MAX_POINTS) ? MAX_POINTS : int'(cfg_point_count);
      r2 = DIST_W'(cfg_radius) * DIST_W'(cfg_radius);
      hit = 1'b0;
      best_d = '0;
      best_id = '0;
      for (int i = 0; i < n; i++) begin
         d = {2'b00, square_diff(point_table[i].x, qx)}
           + {2'b00, square_diff(point_table[i].y, qy)}
           + {2'b00, square_diff(point_table[i].z, qz)};
         if (d < r2) begin
            scan_beats_due.push_back('{KIND_NEIGHBOR, point_table[i].id, d, 1'b0, 1'b0});
            if (!hit || d < best_d) begin
               hit = 1'b1;
               best_d = d;
               best_id = point_table[i].id;
            end
         end
      end
      scan_beats_due.push_back('{KIND_SUMMARY, best_id, best_d, hit, 1'b1});
   endfunction

   // ---------------------------------------------------------------- response side

   always @(posedge clock) begin
      if (idle_enable && stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= int'($urandom_range(0, 3));
      end else begin
         rsp_ready <= 1'b1;
         stall_left <= 0;
      end
   end

   task automatic check_field(input string name, input logic [DIST_W-1:0] want,
                              input logic [DIST_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      scan_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (scan_beats_due.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual kind %0d id %h dist %h",
                     $time, rsp_kind, rsp_result_id, rsp_dist_sq);
            mismatch_count++;
         end else begin
            want = scan_beats_due.pop_front();
            check_field("kind", DIST_W'(want.kind), DIST_W'(rsp_kind));
            check_field("result_id", DIST_W'(want.id), DIST_W'(rsp_result_id));
            check_field("dist_sq", want.dist_sq, rsp_dist_sq);
            check_field("found", DIST_W'(want.found), DIST_W'(rsp_found));
            check_field("last", DIST_W'(want.last), DIST_W'(rsp_last));
         end
      end
   end

   // ---------------------------------------------------------------- request side

   task automatic send_beat(input logic mode, input logic [SLOT_W-1:0] slot,
                            input logic [ID_W-1:0] id, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_slot <= slot;
      req_point_id <= id;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (mode == MODE_LOAD) begin
         point_table[slot] = '{id, x, y, z};
      end else begin
         predict_scan(x, y, z);
      end
   endtask

   task automatic load_point(input int slot, input logic [ID_W-1:0] id,
                             input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z);
      send_beat(MODE_LOAD, SLOT_W'(slot), id, x, y, z);
   endtask

   task automatic run_query(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [COORD_W-1:0] z);
      send_beat(MODE_QUERY, SLOT_W'($urandom_range(0, 31)),
                ID_W'($urandom_range(0, 16'hFFFF)), x, y, z);
   endtask

   task automatic wait_scan_idle();
      req_valid <= 1'b0;
      while (scan_beats_due.size() != 0) @(posedge clock);
      repeat (MAX_POINTS + 4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == REG_POINT_COUNT) begin
         cfg_point_count = value[PCOUNT_W-1:0];
      end else begin
         cfg_radius = value;
      end
      @(posedge clock);
   endtask

   task automatic set_scan_config(input logic [CSR_DATA_W-1:0] count,
                                  input logic [CSR_DATA_W-1:0] radius);
      wait_scan_idle();
      write_reg(REG_POINT_COUNT, count);
      write_reg(REG_RADIUS, radius);
   endtask

   function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] center, int spread);
      logic [COORD_W-1:0] offset;
      offset = COORD_W'($urandom_range(0, 2 * spread));
      return center + offset - spread[COORD_W-1:0];
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_empty_table();
      set_scan_config(0, 16'hFFFF);
      run_query(16'h0000, 16'h0000, 16'h0000);
   endtask

   task automatic test_field_extremes();
      load_point(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      load_point(1, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      load_point(2, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      load_point(3, 16'h1234, 16'h0100, 16'hFF00, 16'h0080);
      // same spot as slot 0, earlier slot must win the summary
      load_point(4, 16'h5555, 16'h0000, 16'h0000, 16'h0000);
      load_point(31, 16'hAAAA, 16'h7FFF, 16'h8000, 16'h0001);
      set_scan_config(5, 16'hFFFF);
      run_query(16'h0000, 16'h0000, 16'h0000);
      run_query(16'h8000, 16'h8000, 16'h8000);
      run_query(16'h7FFF, 16'h7FFF, 16'h7FFF);
      // zero radius, nothing strictly inside
      set_scan_config(5, 16'h0000);
      run_query(16'h0000, 16'h0000, 16'h0000);
      // slot 3 sits exactly on radius 384
      set_scan_config(5, 16'd384);
      run_query(16'h0000, 16'h0000, 16'h0000);
      set_scan_config(5, 16'd385);
      run_query(16'h0000, 16'h0000, 16'h0000);
   endtask

   task automatic test_table_fill();
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [COORD_W-1:0] cz;
      cx = COORD_W'($urandom);
      cy = COORD_W'($urandom);
      cz = COORD_W'($urandom);
      for (int s = 0; s < MAX_POINTS; s++) begin
         load_point(s, ID_W'($urandom_range(0, 16'hFFFF)), near_coord(cx, 16'h400),
                    near_coord(cy, 16'h400), near_coord(cz, 16'h400));
      end
      // all slots in use around the query point with the largest radius, for a long burst of beats
      set_scan_config(CSR_DATA_W'(MAX_POINTS), 16'hFFFF);
      run_query(cx, cy, cz);
      set_scan_config({10'($urandom), 6'd63}, 16'hFFFF);
      run_query(near_coord(cx, 16'h200), near_coord(cy, 16'h200), near_coord(cz, 16'h200));
      set_scan_config(CSR_DATA_W'(MAX_POINTS + 1), 16'h0800);
      run_query(near_coord(cx, 16'h200), near_coord(cy, 16'h200), near_coord(cz, 16'h200));
   endtask

   task automatic test_random_phases(input int phases, input int beats_per_phase);
      logic [COORD_W-1:0]  cx;
      logic [COORD_W-1:0]  cy;
      logic [COORD_W-1:0]  cz;
      logic [CSR_DATA_W-1:0] count;
      logic [CSR_DATA_W-1:0] radius;
      int                  spread;
      int                  n;
      int                  slot;
      for (int p = 0; p < phases; p++) begin
         cx = COORD_W'($urandom);
         cy = COORD_W'($urandom);
         cz = COORD_W'($urandom);
         case ($urandom_range(0, 3))
            0: spread = 16'h0010;
            1: spread = 16'h0100;
            2: spread = 16'h1000;
            default: spread = 16'h7FFF;
         endcase
         case ($urandom_range(0, 7))
            0: count = 0;
            1: count = {10'($urandom), 6'($urandom_range(33, 63))};
            default: count = CSR_DATA_W'($urandom_range(1, MAX_POINTS));
         endcase
         case ($urandom_range(0, 7))
            0: radius = 16'h0000;
            1: radius = 16'hFFFF;
            2: radius = CSR_DATA_W'($urandom_range(0, 16'hFFFF));
            default: radius = (2 * spread > 16'hFFFF) ? 16'hFFFF
                              : CSR_DATA_W'($urandom_range(spread / 2, 2 * spread));
         endcase
         set_scan_config(count, radius);
         n = (count[PCOUNT_W-1:0] > MAX_POINTS) ? MAX_POINTS : int'(count[PCOUNT_W-1:0]);
         for (int b = 0; b < beats_per_phase; b++) begin
            slot = (n > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, n - 1)
                                                        : $urandom_range(0, MAX_POINTS - 1);
            if ($urandom_range(0, 9) == 0) begin
               send_beat(1'($urandom_range(0, 1)), SLOT_W'(slot), ID_W'($urandom),
                         COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
            end else if (b < 4 || $urandom_range(0, 3) == 0) begin
               load_point(slot, ID_W'($urandom), near_coord(cx, spread),
                          near_coord(cy, spread), near_coord(cz, spread));
            end else begin
               run_query(near_coord(cx, spread), near_coord(cy, spread), near_coord(cz, spread));
            end
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_field_extremes();
      test_table_fill();
      test_random_phases(8, 22);
      wait_scan_idle();
      idle_enable = 1'b0;
      test_random_phases(2, 15);
      wait_scan_idle();
      if (mismatch_count == 0 && scan_beats_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
